FILE: hdl/mhic_pkg.sv
package mhic_pkg;

  localparam int AXES = 3;
  localparam int RAW_W = 20;
  localparam int OFS_W = 21;
  localparam int OUT_W = 22;
  localparam int LEN_W = 16;
  localparam int COUNT_W = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // count of all ones: calibration finished, no more samples taken
  localparam logic [COUNT_W-1:0] COUNT_STOPPED = '1;
  localparam logic [COUNT_W-1:0] COUNT_EMPTY = '0;
  localparam logic [COUNT_W-1:0] COUNT_SEEDED = COUNT_W'(1);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(200);

  typedef logic signed [RAW_W-1:0] reading_t;
  typedef logic signed [OFS_W-1:0] offset_t;
  typedef logic signed [OUT_W-1:0] corrected_t;

  // one frame after decoding: unbiased readings plus the calibration flag
  typedef struct packed {
    logic               cal;
    reading_t [AXES-1:0] v;
  } item_t;

endpackage

FILE: hdl/mhic_front.sv
module mhic_front
  import mhic_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [71:0] in_data,
  input  logic        in_cal,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  logic [RAW_W-1:0] raw [AXES];
  item_t            item_next;

  // per axis: high byte, mid byte, then the high nibble of the axis's own extra byte
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      raw[a] = {in_data[16*a +: 8], in_data[16*a + 8 +: 8], in_data[48 + 8*a + 4 +: 4]};
    end
    item_next.cal = in_cal;
    for (int a = 0; a < AXES; a++) begin
      // subtracting the 2^19 bias is an inversion of the top bit
      item_next.v[a] = reading_t'({~raw[a][RAW_W-1], raw[a][RAW_W-2:0]});
    end
  end

  assign in_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_item <= item_next;
    end
  end

endmodule

FILE: hdl/mhic_queue.sv
module mhic_queue
  import mhic_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: hdl/mhic_back.sv
module mhic_back
  import mhic_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [LEN_W-1:0]       cfg_data,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  item_t                  q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output corrected_t [AXES-1:0]  out_corr,
  output logic                   out_done
);

  logic [LEN_W-1:0]   cal_len;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  reading_t           min_r [AXES];
  reading_t           max_r [AXES];
  offset_t            offset [AXES];
  reading_t           min_next [AXES];
  reading_t           max_next [AXES];
  corrected_t [AXES-1:0] corr_next;
  logic               take;
  logic               cal_active;
  logic               seeding;
  logic               latch;

  assign q_ready    = !out_valid || out_ready;
  assign take       = q_valid && q_ready;
  assign cal_active = q_item.cal && (count != COUNT_STOPPED);
  assign seeding    = (count == COUNT_EMPTY);
  // count-1 samples taken beyond the seed, this one makes count
  assign latch      = cal_active && !seeding && (count >= {1'b0, cal_len});

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      // 2v - (min+max), using the offsets held before this item
      corr_next[a] = {q_item.v[a][RAW_W-1], q_item.v[a], 1'b0} - OUT_W'(offset[a]);
      if (seeding) begin
        min_next[a] = q_item.v[a];
        max_next[a] = q_item.v[a];
      end else begin
        min_next[a] = (q_item.v[a] < min_r[a]) ? q_item.v[a] : min_r[a];
        max_next[a] = (q_item.v[a] > max_r[a]) ? q_item.v[a] : max_r[a];
      end
    end
    if (seeding) begin
      count_next = COUNT_SEEDED;
    end else if (latch) begin
      count_next = COUNT_STOPPED;
    end else begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_len   <= LEN_RESET;
      count     <= COUNT_EMPTY;
      out_valid <= 1'b0;
      out_done  <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        min_r[a]  <= '0;
        max_r[a]  <= '0;
        offset[a] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        cal_len <= cfg_data;
      end
      if (q_ready) begin
        out_valid <= q_valid;
      end
      if (take) begin
        out_done <= latch;
        if (cal_active) begin
          count <= count_next;
          for (int a = 0; a < AXES; a++) begin
            min_r[a] <= min_next[a];
            max_r[a] <= max_next[a];
            if (latch) begin
              offset[a] <= OFS_W'(min_next[a]) + OFS_W'(max_next[a]);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_corr <= corr_next;
    end
  end

endmodule

FILE: hdl/magnetometer_hard_iron_correction_top.sv
// Hard-iron correction for a three-axis magnetometer. Each input beat is one
// nine-byte frame; each axis reading is high:mid:extra[7:4], bias removed, and
// the result beat carries 2*reading - (min+max) per axis in half-LSB units,
// exact and never saturating. A beat with tuser set is also a calibration
// sample: the first seeds the per-axis min/max, the next calibration_length
// samples widen them, and the last of those latches min+max as the new offset
// (that beat still uses the old offset and flags calibration_done). After
// that calibration samples are ignored until reset. A length of zero acts as
// one. It takes one beat per clock while the output accepts every beat; each
// beat passes the decode register, the two-entry queue and the output register.
// Input and output stall independently through the queue. cfg writes are
// taken every cycle and are only legal while the block is idle.
module magnetometer_hard_iron_correction_top
  import mhic_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // calibration_length register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // input frames
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] x_high_byte, [15:8] x_mid_byte, [23:16] y_high_byte,
  // [31:24] y_mid_byte, [39:32] z_high_byte, [47:40] z_mid_byte,
  // [55:48] x_extra_byte, [63:56] y_extra_byte, [71:64] z_extra_byte
  input  logic [71:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  // corrected results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [21:0] x_corrected, [43:22] y_corrected, [65:44] z_corrected, rest zero
  output logic [71:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser    // [0] calibration_done
);

  logic                  fq_valid;
  logic                  fq_ready;
  item_t                 fq_item;
  logic                  qb_valid;
  logic                  qb_ready;
  item_t                 qb_item;
  corrected_t [AXES-1:0] corr;
  logic                  done;

  assign cfg_ready = 1'b1;

  // front: unpack and unbias the frame
  mhic_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_cal   (s_axis_tuser[0]),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  // short queue decoupling front from back
  mhic_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  // back: min/max tracking, offset latch and correction
  mhic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_corr  (corr),
    .out_done  (done)
  );

  assign m_axis_tdata = {6'b0, corr};
  assign m_axis_tuser = done;

endmodule

FILE: hdl/mhic_checker.sv
module mhic_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic done_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      done_seen <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[0]) begin
      done_seen <= 1'b1;
    end
  end

  // a held result keeps its beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // offsets latch only once per reset
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[0] |-> !done_seen)
    else $error("calibration_done seen twice");

  // padding above the three results stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[71:66] == 6'b0)
    else $error("tdata padding not zero");

  // nothing is shown straight out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind magnetometer_hard_iron_correction_top mhic_checker u_mhic_checker (.*);

FILE: tb/sv/tb_magnetometer_hard_iron_correction_top.sv
`timescale 1ns / 100ps

module tb_magnetometer_hard_iron_correction_top;
  import mhic_pkg::*;

  // sized for the worst case, with both sides stalling
  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_AFTER = 100;

  // one expected output beat
  typedef struct packed {
    logic                         done;
    corrected_t [AXES-1:0]        axis;
  } correction_t;

  // Holds its own copy of the calibration state and predicts each output
  // beat as the input beat is taken.
  class calibration_scoreboard;
    logic [LEN_W-1:0]   cal_length;
    logic [COUNT_W-1:0] cal_count;
    reading_t           axis_lo [AXES];
    reading_t           axis_hi [AXES];
    offset_t            offset [AXES];
    correction_t        due [$];
    int                 beats_seen;
    int                 mismatches;

    function new();
      cal_length = LEN_RESET;
      cal_count  = COUNT_EMPTY;
      for (int a = 0; a < AXES; a++) begin
        axis_lo[a] = '0;
        axis_hi[a] = '0;
        offset[a]  = '0;
      end
      beats_seen = 0;
      mismatches = 0;
    endfunction

    function void set_length(logic [LEN_W-1:0] value);
      cal_length = value;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_frame(logic mode, logic [71:0] frame);
      reading_t         v [AXES];
      logic [RAW_W-1:0] raw;
      correction_t      want;
      want = '0;
      for (int a = 0; a < AXES; a++) begin
        raw  = {frame[16*a +: 8], frame[16*a+8 +: 8], frame[48+8*a+4 +: 4]};
        // flipping the top bit takes off the 524288 bias
        v[a] = reading_t'(raw ^ 20'h80000);
        // always the offset held before this beat, even on the latching one
        want.axis[a] = corrected_t'(2 * int'(v[a]) - int'(offset[a]));
      end
      if (mode && cal_count != COUNT_STOPPED) begin
        if (cal_count == COUNT_EMPTY) begin
          for (int a = 0; a < AXES; a++) begin
            axis_lo[a] = v[a];
            axis_hi[a] = v[a];
          end
          cal_count = COUNT_SEEDED;
        end else begin
          for (int a = 0; a < AXES; a++) begin
            if (v[a] > axis_hi[a])
              axis_hi[a] = v[a];
            else if (v[a] < axis_lo[a])
              axis_lo[a] = v[a];
          end
          cal_count++;
          // a length of zero latches on the first further sample, like one
          if ((cal_count - COUNT_SEEDED) >= COUNT_W'(cal_length)) begin
            for (int a = 0; a < AXES; a++)
              offset[a] = offset_t'(int'(axis_lo[a]) + int'(axis_hi[a]));
            cal_count = COUNT_STOPPED;
            want.done = 1'b1;
          end
        end
      end
      due.push_back(want);
    endfunction

    task report(string what, longint got, longint want);
      if (mismatches < QUIET_AFTER)
        $display("MISMATCH beat %0d %s: got %0d, want %0d", beats_seen, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [71:0] data, logic done);
      correction_t want;
      corrected_t  got;
      beats_seen++;
      if (due.size() == 0) begin
        report("output beat with nothing pending", longint'(data[21:0]), 0);
        return;
      end
      want = due.pop_front();
      for (int a = 0; a < AXES; a++) begin
        got = corrected_t'(data[22*a +: 22]);
        if (got !== want.axis[a])
          report($sformatf("axis %0d corrected", a), got, want.axis[a]);
      end
      if (done !== want.done)
        report("calibration_done", done, want.done);
      if (data[71:66] !== '0)
        report("tdata padding", data[71:66], 0);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  calibration_scoreboard sb;
  bit                    no_idle;
  int                    cycle_count = 0;

  // calibration samples are drawn from a box so that min+max is not near zero
  logic [AXES-1:0][RAW_W-1:0] cluster_base;
  int                         cluster_span [AXES];

  magnetometer_hard_iron_correction_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // gap before a beat on either side; none at all during no_idle stretches
  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  // raw readings into the nine-byte frame; the ignored low nibbles get noise
  function automatic logic [71:0] pack_frame(logic [AXES-1:0][RAW_W-1:0] raw);
    logic [71:0] f;
    f = '0;
    for (int a = 0; a < AXES; a++) begin
      f[16*a +: 8]     = raw[a][19:12];
      f[16*a+8 +: 8]   = raw[a][11:4];
      f[48+8*a +: 8]   = {raw[a][3:0], 4'($urandom)};
    end
    return f;
  endfunction

  function automatic logic [71:0] rand_frame();
    return 72'({$urandom, $urandom, $urandom});
  endfunction

  function automatic void pick_cluster();
    for (int a = 0; a < AXES; a++) begin
      cluster_span[a] = $urandom_range(0, 8191);
      cluster_base[a] = RAW_W'($urandom_range(0, (1 << RAW_W) - 1 - cluster_span[a]));
    end
  endfunction

  function automatic logic [71:0] cluster_frame();
    logic [AXES-1:0][RAW_W-1:0] raw;
    for (int a = 0; a < AXES; a++)
      raw[a] = cluster_base[a] + RAW_W'($urandom_range(0, cluster_span[a]));
    return pack_frame(raw);
  endfunction

  // one input beat; the prediction is made at the edge that takes it
  task automatic send_frame(logic mode, logic [71:0] frame);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = frame;
    s_axis_tuser  = mode;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_frame(mode, frame);
  endtask

  // only once the block has drained
  task automatic write_length(logic [LEN_W-1:0] value);
    @(negedge clk) s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_length(value);
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // field extremes: all clear, all set, zero reading, mixed ends, bit patterns
  task automatic send_extremes(logic mode);
    send_frame(mode, '0);
    send_frame(mode, '1);
    send_frame(mode, pack_frame({20'h80000, 20'h80000, 20'h80000}));
    send_frame(mode, pack_frame({20'h80000, 20'hFFFFF, 20'h00000}));
    send_frame(mode, pack_frame({20'h7FFFF, 20'h00000, 20'hFFFFF}));
    send_frame(mode, {9{8'hAA}});
    send_frame(mode, {9{8'h55}});
  endtask

  // cal_share in tenths: how many beats carry the calibration flag
  task automatic run_random(int count, int cal_share);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < cal_share)
        send_frame(1'b1, cluster_frame());
      else
        send_frame(1'b0, rand_frame());
    end
  endtask

  // output side: random stall before each beat, check on acceptance
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = draw_gap();
      repeat (stall) @(negedge clk) m_axis_tready = 1'b0;
      @(negedge clk) m_axis_tready = 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end
  end

  initial begin
    logic [AXES-1:0][RAW_W-1:0] lo, hi, mid;
    sb            = new();
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    no_idle       = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed part, at the reset length of 200. No offset is held yet, so
    // the extremes show the full range of the raw decode.
    send_extremes(1'b0);

    // seed, an uncalibrated beat, then widen up, widen down, and a sample inside the box
    pick_cluster();
    for (int a = 0; a < AXES; a++) begin
      lo[a]  = cluster_base[a];
      hi[a]  = cluster_base[a] + RAW_W'(cluster_span[a]);
      mid[a] = cluster_base[a] + RAW_W'(cluster_span[a] / 2);
    end
    send_frame(1'b1, pack_frame(mid));
    send_frame(1'b0, rand_frame());
    send_frame(1'b1, pack_frame(hi));
    send_frame(1'b1, pack_frame(lo));
    send_frame(1'b1, pack_frame(mid));

    // Longest length: calibration runs on through the whole phase and
    // never latches.
    write_length(16'hFFFF);
    run_random(900, 6);

    // A length of zero with far more samples already taken: the next
    // calibration beat latches, still corrected with the old (zero) offset.
    write_length(16'h0000);
    send_frame(1'b1, cluster_frame());

    // Calibration has stopped: flagged beats, extremes included, are only
    // corrected, now against the latched offsets.
    send_extremes(1'b1);
    run_random(450, 5);
    write_length(16'h0001);
    run_random(450, 5);

    @(negedge clk) s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
